@@ rtl/raic_pkg.sv @@
// Types and codes shared by the relay interlock controller.
`default_nettype none

package raic_pkg;

   // Item kinds
   localparam logic OP_COMMAND = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // Device selectors
   localparam logic [3:0] DEV_LIGHT   = 4'd0;
   localparam logic [3:0] DEV_CURTAIN = 4'd1;
   localparam logic [3:0] DEV_SCREEN  = 4'd2;
   localparam logic [3:0] DEV_RAW     = 4'd3;

   // Light commands
   localparam logic [3:0] CMD_LIGHT_ON     = 4'd0;
   localparam logic [3:0] CMD_LIGHT_OFF    = 4'd1;
   localparam logic [3:0] CMD_LIGHT_TOGGLE = 4'd2;
   localparam logic [3:0] CMD_LIGHT_GET    = 4'd3;

   // Axis commands
   localparam logic [3:0] CMD_AXIS_FWD  = 4'd0;
   localparam logic [3:0] CMD_AXIS_REV  = 4'd1;
   localparam logic [3:0] CMD_AXIS_STOP = 4'd2;
   localparam logic [3:0] CMD_AXIS_GET  = 4'd3;

   // Raw relay commands
   localparam logic [3:0] CMD_RAW_ALL_OFF = 4'd0;
   localparam logic [3:0] CMD_RAW_SET     = 4'd1;
   localparam logic [3:0] CMD_RAW_GET     = 4'd2;

   // Payload lengths the raw commands expect
   localparam logic [7:0] RAW_SET_LEN = 8'd2;
   localparam logic [7:0] RAW_GET_LEN = 8'd1;

   // Error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_PAYLOAD   = 3'd1;
   localparam logic [2:0] ERR_COMMAND   = 3'd2;
   localparam logic [2:0] ERR_INTERLOCK = 3'd3;
   localparam logic [2:0] ERR_DEVICE    = 3'd4;

   // Register indexes
   localparam logic [2:0] REG_DEADTIME      = 3'd0;
   localparam logic [2:0] REG_CURTAIN_LIMIT = 3'd1;
   localparam logic [2:0] REG_SCREEN_LIMIT  = 3'd2;
   localparam logic [2:0] REG_LIGHT_LINE    = 3'd3;
   localparam logic [2:0] REG_CURTAIN_OPEN  = 3'd4;
   localparam logic [2:0] REG_CURTAIN_CLOSE = 3'd5;
   localparam logic [2:0] REG_SCREEN_UP     = 3'd6;
   localparam logic [2:0] REG_SCREEN_DOWN   = 3'd7;

   // Register reset values
   localparam logic [15:0] DEADTIME_RST  = 16'd100;
   localparam logic [23:0] RUN_LIMIT_RST = 24'd30000;

   typedef enum logic [1:0] {
      MOT_STOP = 2'd0,
      MOT_FWD  = 2'd1,
      MOT_REV  = 2'd2
   } motion_type;

   typedef struct packed {
      motion_type  motion;
      motion_type  pending;
      logic [15:0] dead_left;
      logic [23:0] run_left;
   } axis_type;

endpackage

`default_nettype wire

@@ rtl/relay_axis_interlock_controller.sv @@
// Relay interlock controller for one light and two reversing axes.
//
//  channel | direction | handshake          | contents
//  req_    | in        | req_valid/ready    | tick or command item
//  rsp_    | out       | rsp_valid/ready    | response fields and relay lines
//  csr_    | in/out    | APB psel/penable   | deadtime, run limits, line roles
//
// One item per cycle while the response side does not stall. An accepted item
// sits in the input register, is applied to the light, line and axis state
// and lands in the response register. A new item is taken while a response
// waits, as long as the input register is free. Reset clears the valid flags
// and the light, line and axis state and loads the register defaults.
`default_nettype none

module relay_axis_interlock_controller #(
   parameter int unsigned RELAY_LINES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_seq_tag,
   input  wire logic [3:0]  req_device_sel,
   input  wire logic [3:0]  req_command_code,
   input  wire logic [7:0]  req_channel_index,
   input  wire logic [7:0]  req_channel_level,
   input  wire logic [7:0]  req_payload_count,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_responded,
   output logic [7:0]       rsp_seq_echo,
   output logic [3:0]       rsp_device_echo,
   output logic [3:0]       rsp_command_echo,
   output logic             rsp_status_ok,
   output logic [2:0]       rsp_error_code,
   output logic [1:0]       rsp_state_value,
   output logic [7:0]       rsp_relay_lines,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   import raic_pkg::*;

   localparam int unsigned IDX_W = $clog2(RELAY_LINES);

   typedef struct packed {
      axis_type               ax;
      logic [RELAY_LINES-1:0] lines;
      logic                   refused;
   } go_type;

   // ---------------------------------------------------------------- helpers

   // Out-of-range line indexes are ignored on write and read as 0
   function automatic logic [RELAY_LINES-1:0] line_set(
      input logic [RELAY_LINES-1:0] v,
      input logic [7:0]             idx,
      input logic                   on
   );
      logic [RELAY_LINES-1:0] r;
      r = v;
      if (32'(idx) < RELAY_LINES) begin
         r[idx[IDX_W-1:0]] = on;
      end
      return r;
   endfunction

   function automatic logic line_get(
      input logic [RELAY_LINES-1:0] v,
      input logic [7:0]             idx
   );
      logic r;
      r = 1'b0;
      if (32'(idx) < RELAY_LINES) begin
         r = v[idx[IDX_W-1:0]];
      end
      return r;
   endfunction

   function automatic go_type axis_go(
      input axis_type               ax,
      input motion_type             dir,
      input logic [23:0]            limit,
      input logic [15:0]            deadtime,
      input logic [7:0]             fl,
      input logic [7:0]             rl,
      input logic [RELAY_LINES-1:0] lines
   );
      go_type r;
      r.ax      = ax;
      r.lines   = lines;
      r.refused = 1'b0;
      if (ax.motion != MOT_STOP) begin
         if (ax.motion == dir) begin
            r.ax.run_left = limit;
         end else begin
            // reversal: drop both relays and arm the deadtime
            r.lines        = line_set(line_set(lines, fl, 1'b0), rl, 1'b0);
            r.ax.motion    = MOT_STOP;
            r.ax.pending   = dir;
            r.ax.dead_left = deadtime;
         end
      end else if (ax.pending != MOT_STOP && ax.dead_left != 16'd0) begin
         r.refused = 1'b1;
      end else begin
         if (dir == MOT_FWD) begin
            r.lines = line_set(line_set(lines, rl, 1'b0), fl, 1'b1);
         end else begin
            r.lines = line_set(line_set(lines, fl, 1'b0), rl, 1'b1);
         end
         r.ax.motion   = dir;
         r.ax.run_left = limit;
         r.ax.pending  = MOT_STOP;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- config

   logic [15:0] deadtime_ff;
   logic [23:0] curtain_limit_ff;
   logic [23:0] screen_limit_ff;
   logic [2:0]  light_line_ff;
   logic [2:0]  curtain_open_ff;
   logic [2:0]  curtain_close_ff;
   logic [2:0]  screen_up_ff;
   logic [2:0]  screen_down_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         deadtime_ff      <= DEADTIME_RST;
         curtain_limit_ff <= RUN_LIMIT_RST;
         screen_limit_ff  <= RUN_LIMIT_RST;
         light_line_ff    <= 3'd0;
         curtain_open_ff  <= 3'd1;
         curtain_close_ff <= 3'd2;
         screen_up_ff     <= 3'd3;
         screen_down_ff   <= 3'd4;
      end else if (csr_write) begin
         case (csr_index)
            REG_DEADTIME:      deadtime_ff      <= csr_pwdata[15:0];
            REG_CURTAIN_LIMIT: curtain_limit_ff <= csr_pwdata[23:0];
            REG_SCREEN_LIMIT:  screen_limit_ff  <= csr_pwdata[23:0];
            REG_LIGHT_LINE:    light_line_ff    <= csr_pwdata[2:0];
            REG_CURTAIN_OPEN:  curtain_open_ff  <= csr_pwdata[2:0];
            REG_CURTAIN_CLOSE: curtain_close_ff <= csr_pwdata[2:0];
            REG_SCREEN_UP:     screen_up_ff     <= csr_pwdata[2:0];
            REG_SCREEN_DOWN:   screen_down_ff   <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_DEADTIME:      csr_prdata = {16'd0, deadtime_ff};
         REG_CURTAIN_LIMIT: csr_prdata = {8'd0, curtain_limit_ff};
         REG_SCREEN_LIMIT:  csr_prdata = {8'd0, screen_limit_ff};
         REG_LIGHT_LINE:    csr_prdata = {29'd0, light_line_ff};
         REG_CURTAIN_OPEN:  csr_prdata = {29'd0, curtain_open_ff};
         REG_CURTAIN_CLOSE: csr_prdata = {29'd0, curtain_close_ff};
         REG_SCREEN_UP:     csr_prdata = {29'd0, screen_up_ff};
         REG_SCREEN_DOWN:   csr_prdata = {29'd0, screen_down_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // Per-axis views: index 0 curtain, 1 screen
   logic [7:0]  fwd_idx [2];
   logic [7:0]  rev_idx [2];
   logic [23:0] limit   [2];

   assign fwd_idx[0] = {5'd0, curtain_open_ff};
   assign rev_idx[0] = {5'd0, curtain_close_ff};
   assign fwd_idx[1] = {5'd0, screen_up_ff};
   assign rev_idx[1] = {5'd0, screen_down_ff};
   assign limit[0]   = curtain_limit_ff;
   assign limit[1]   = screen_limit_ff;

   // ---------------------------------------------------------------- input stage

   logic       in_valid_ff;
   logic       in_valid_in;
   logic       in_op_ff;
   logic [7:0] in_seq_ff;
   logic [3:0] in_dev_ff;
   logic [3:0] in_cmd_ff;
   logic [7:0] in_chan_ff;
   logic [7:0] in_lvl_ff;
   logic [7:0] in_plen_ff;
   logic       advance;
   logic       req_take;

   logic       out_valid_ff;
   logic       out_valid_in;

   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign req_take  = req_valid & req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_op;
         in_seq_ff  <= req_seq_tag;
         in_dev_ff  <= req_device_sel;
         in_cmd_ff  <= req_command_code;
         in_chan_ff <= req_channel_index;
         in_lvl_ff  <= req_channel_level;
         in_plen_ff <= req_payload_count;
      end
   end

   // ---------------------------------------------------------------- state update

   logic                   light_flag_ff;
   logic                   light_flag_in;
   logic [RELAY_LINES-1:0] lines_ff;
   logic [RELAY_LINES-1:0] lines_in;
   axis_type               axis_ff [2];
   axis_type               axis_in [2];

   logic       responded_in;
   logic [2:0] err_in;
   logic [1:0] val_in;
   logic [31:0] lines_wide;

   logic        responded_ff;
   logic [7:0]  seq_echo_ff;
   logic [3:0]  dev_echo_ff;
   logic [3:0]  cmd_echo_ff;
   logic [2:0]  err_ff;
   logic [1:0]  val_ff;
   logic [7:0]  relay_ff;

   logic ax_sel;
   assign ax_sel = (in_dev_ff == DEV_SCREEN);

   always_comb begin
      go_type     g;
      motion_type p;
      g             = '0;
      p             = MOT_STOP;
      light_flag_in = light_flag_ff;
      lines_in      = lines_ff;
      axis_in[0]    = axis_ff[0];
      axis_in[1]    = axis_ff[1];
      responded_in  = 1'b0;
      err_in        = ERR_NONE;
      val_in        = 2'd0;

      if (in_op_ff == OP_TICK) begin
         // axes are handled in order; line writes of the screen land last
         for (int a = 0; a < 2; a++) begin
            if (axis_in[a].dead_left != 16'd0) begin
               axis_in[a].dead_left = axis_in[a].dead_left - 16'd1;
            end
            if (axis_in[a].run_left != 24'd0) begin
               axis_in[a].run_left = axis_in[a].run_left - 24'd1;
            end
            if (axis_in[a].pending != MOT_STOP && axis_in[a].dead_left == 16'd0) begin
               p                  = axis_in[a].pending;
               axis_in[a].pending = MOT_STOP;
               g = axis_go(axis_in[a], p, limit[a], deadtime_ff,
                           fwd_idx[a], rev_idx[a], lines_in);
               axis_in[a] = g.ax;
               lines_in   = g.lines;
            end
            if (axis_in[a].motion != MOT_STOP && axis_in[a].run_left == 24'd0) begin
               lines_in   = line_set(line_set(lines_in, fwd_idx[a], 1'b0),
                                     rev_idx[a], 1'b0);
               axis_in[a] = '0;
            end
         end
      end else begin
         case (in_dev_ff)
            DEV_LIGHT: begin
               responded_in = 1'b1;
               case (in_cmd_ff)
                  CMD_LIGHT_ON: begin
                     light_flag_in = 1'b1;
                     lines_in = line_set(lines_in, {5'd0, light_line_ff}, 1'b1);
                  end
                  CMD_LIGHT_OFF: begin
                     light_flag_in = 1'b0;
                     lines_in = line_set(lines_in, {5'd0, light_line_ff}, 1'b0);
                  end
                  CMD_LIGHT_TOGGLE: begin
                     light_flag_in = ~light_flag_ff;
                     lines_in = line_set(lines_in, {5'd0, light_line_ff}, ~light_flag_ff);
                  end
                  CMD_LIGHT_GET: ;
                  default: err_in = ERR_COMMAND;
               endcase
               val_in = {1'b0, light_flag_in};
            end
            DEV_CURTAIN, DEV_SCREEN: begin
               responded_in = 1'b1;
               case (in_cmd_ff)
                  CMD_AXIS_FWD, CMD_AXIS_REV: begin
                     p = (in_cmd_ff == CMD_AXIS_FWD) ? MOT_FWD : MOT_REV;
                     g = axis_go(axis_ff[ax_sel], p, limit[ax_sel], deadtime_ff,
                                 fwd_idx[ax_sel], rev_idx[ax_sel], lines_ff);
                     axis_in[ax_sel] = g.ax;
                     lines_in        = g.lines;
                     err_in          = g.refused ? ERR_INTERLOCK : ERR_NONE;
                  end
                  CMD_AXIS_STOP: begin
                     lines_in = line_set(line_set(lines_ff, fwd_idx[ax_sel], 1'b0),
                                         rev_idx[ax_sel], 1'b0);
                     axis_in[ax_sel] = '0;
                  end
                  CMD_AXIS_GET: ;
                  default: err_in = ERR_COMMAND;
               endcase
               val_in = 2'(axis_in[ax_sel].motion);
            end
            DEV_RAW: begin
               responded_in = 1'b1;
               case (in_cmd_ff)
                  CMD_RAW_ALL_OFF: begin
                     lines_in      = '0;
                     light_flag_in = 1'b0;
                     axis_in[0]    = '0;
                     axis_in[1]    = '0;
                  end
                  CMD_RAW_SET: begin
                     if (in_plen_ff == RAW_SET_LEN) begin
                        lines_in = line_set(lines_ff, in_chan_ff, in_lvl_ff != 8'd0);
                        if (32'(in_chan_ff) >= RELAY_LINES) begin
                           err_in = ERR_PAYLOAD;
                        end
                        val_in = {1'b0, line_get(lines_in, in_chan_ff)};
                     end else begin
                        err_in = ERR_COMMAND;
                     end
                  end
                  CMD_RAW_GET: begin
                     if (in_plen_ff == RAW_GET_LEN) begin
                        val_in = {1'b0, line_get(lines_ff, in_chan_ff)};
                     end else begin
                        err_in = ERR_COMMAND;
                     end
                  end
                  default: err_in = ERR_COMMAND;
               endcase
            end
            default: err_in = ERR_DEVICE;
         endcase
      end
   end

   assign lines_wide = 32'(lines_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         light_flag_ff <= 1'b0;
         lines_ff      <= '0;
         axis_ff[0]    <= '0;
         axis_ff[1]    <= '0;
      end else if (advance) begin
         light_flag_ff <= light_flag_in;
         lines_ff      <= lines_in;
         axis_ff[0]    <= axis_in[0];
         axis_ff[1]    <= axis_in[1];
      end
   end

   // ---------------------------------------------------------------- response stage

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ticks carry nothing but the relay lines
   always_ff @(posedge clock) begin
      if (advance) begin
         responded_ff <= responded_in;
         seq_echo_ff  <= (in_op_ff == OP_TICK) ? 8'd0 : in_seq_ff;
         dev_echo_ff  <= (in_op_ff == OP_TICK) ? 4'd0 : in_dev_ff;
         cmd_echo_ff  <= (in_op_ff == OP_TICK) ? 4'd0 : in_cmd_ff;
         err_ff       <= err_in;
         val_ff       <= val_in;
         relay_ff     <= lines_wide[7:0];
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_responded    = responded_ff;
   assign rsp_seq_echo     = seq_echo_ff;
   assign rsp_device_echo  = dev_echo_ff;
   assign rsp_command_echo = cmd_echo_ff;
   assign rsp_status_ok    = (err_ff == ERR_NONE) & responded_ff;
   assign rsp_error_code   = err_ff;
   assign rsp_state_value  = val_ff;
   assign rsp_relay_lines  = relay_ff;

   // ---------------------------------------------------------------- checks

   // a pending direction only exists while the axis is stopped
   a_curtain_pending_stopped: assert property (@(posedge clock) disable iff (reset)
      axis_ff[0].pending != MOT_STOP |-> axis_ff[0].motion == MOT_STOP)
      else $error("curtain has a pending direction while moving");

   a_screen_pending_stopped: assert property (@(posedge clock) disable iff (reset)
      axis_ff[1].pending != MOT_STOP |-> axis_ff[1].motion == MOT_STOP)
      else $error("screen has a pending direction while moving");

   // the request side only stalls when both stages are occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff && !rsp_ready)
      else $error("request stalled with a free stage");

endmodule

`default_nettype wire
